// File: src/delayed_event_timer_queue_defines.svh
// Assertion macros shared by the timer queue RTL.
// Needs clk and arst_n in the scope of use; no other dependencies.
`ifndef DELAYED_EVENT_TIMER_QUEUE_DEFINES_SVH
`define DELAYED_EVENT_TIMER_QUEUE_DEFINES_SVH

// Condition and consequence in the same cycle.
`define DETQ_ASSERT_SAME(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Consequence in the cycle after the condition.
`define DETQ_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: src/detq_pkg.sv
// Types and constants of the delayed event timer queue.
// No dependencies.
`default_nettype none

package detq_pkg;

	localparam int TIME_W        = 48;
	localparam int RELEASE_LIMIT = 16;
	localparam int REL_CNT_W     = 5;
	localparam int REL_IDX_W     = 4;

	typedef enum logic [1:0] {
		OP_SCHEDULE = 2'd0,
		OP_TICK     = 2'd1,
		OP_CANCEL   = 2'd2,
		OP_UNUSED   = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		STAT_SCHEDULED  = 3'd0,
		STAT_NULL       = 3'd1,
		STAT_FULL       = 3'd2,
		STAT_CANCELLED  = 3'd3,
		STAT_NOT_FOUND  = 3'd4,
		STAT_RELEASED   = 3'd5,
		STAT_NONE_READY = 3'd6
	} status_t;

	// Command kinds after the front has classified an item.
	typedef enum logic [2:0] {
		CMD_SCHED,
		CMD_NULL,
		CMD_TICK,
		CMD_CANCEL,
		CMD_CANCEL_NONE,
		CMD_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [31:0] delay_ms;
		logic [15:0] event_handle;
		logic [7:0]  target_ref;
		logic [15:0] send_ref;
	} cmd_t;

	typedef struct packed {
		logic [TIME_W-1:0] due;
		logic [15:0]       event_handle;
		logic [7:0]        target_ref;
		logic [15:0]       send_ref;
		logic [15:0]       order;
	} slot_t;

	typedef struct packed {
		logic [15:0] event_handle;
		logic [7:0]  target_ref;
		logic [15:0] send_ref;
	} rel_t;

endpackage

`default_nettype wire

// File: src/detq_ifs.sv
// Valid/ready channel interfaces for the timer queue: command in, response out.
// No dependencies.
`default_nettype none

interface detq_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [31:0] delay_ms;
	logic [15:0] event_handle;
	logic [7:0]  target_ref;
	logic [15:0] send_ref;

	modport source (output valid, opcode, delay_ms, event_handle, target_ref, send_ref,
		input ready);
	modport sink (input valid, opcode, delay_ms, event_handle, target_ref, send_ref,
		output ready);
endinterface

interface detq_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] out_event_handle;
	logic [7:0]  out_target_ref;
	logic [15:0] out_send_ref;
	logic        ready_pending;
	logic [31:0] time_to_next;
	logic        last;

	modport source (output valid, status, out_event_handle, out_target_ref, out_send_ref,
		ready_pending, time_to_next, last, input ready);
	modport sink (input valid, status, out_event_handle, out_target_ref, out_send_ref,
		ready_pending, time_to_next, last, output ready);
endinterface

`default_nettype wire

// File: src/detq_front.sv
// Front of the timer queue: takes command beats, classifies them, two-entry queue.
// Depends on detq_pkg and detq_cmd_if.
`default_nettype none

module detq_front (
	input  wire             clk,
	input  wire             arst_n,
	detq_cmd_if.sink        cmd,
	output logic            head_valid,
	output detq_pkg::cmd_t  head,
	input  wire             pop
);
	import detq_pkg::*;

	cmd_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	cmd_t       cls;
	logic       push;

	always_comb begin
		cls.delay_ms     = cmd.delay_ms;
		cls.event_handle = cmd.event_handle;
		cls.target_ref   = cmd.target_ref;
		cls.send_ref     = cmd.send_ref;
		unique case (opcode_t'(cmd.opcode))
			OP_SCHEDULE: cls.kind = (cmd.event_handle == 16'd0) ? CMD_NULL : CMD_SCHED;
			OP_TICK:     cls.kind = CMD_TICK;
			OP_CANCEL:   cls.kind = (cmd.send_ref == 16'd0) ? CMD_CANCEL_NONE : CMD_CANCEL;
			default:     cls.kind = CMD_NOP;
		endcase
	end

	assign cmd.ready  = (count_q != 2'd2);
	assign push       = cmd.valid && cmd.ready;
	assign head_valid = (count_q != 2'd0);
	assign head       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

`default_nettype wire

// File: src/detq_back.sv
// Back of the timer queue: slot store, scan engine, release buffer, response register.
// Depends on detq_pkg, detq_rsp_if and the assertion macro header.
`default_nettype none
`include "delayed_event_timer_queue_defines.svh"

module detq_back #(
	parameter int DEPTH = 16
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             head_valid,
	input  detq_pkg::cmd_t  head,
	output logic            pop,
	detq_rsp_if.source      rsp
);
	import detq_pkg::*;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_DECIDE = 4'b0100,
		S_EMIT   = 4'b1000
	} state_t;

	typedef enum logic [1:0] {
		MODE_REL,
		MODE_FINAL,
		MODE_CANCEL
	} mode_t;

	state_t            state_q;
	mode_t             mode_q;
	status_t           status_q;
	logic [TIME_W-1:0] now_q;
	logic [15:0]       ins_cnt_q;
	logic [DEPTH-1:0]  valid_q;
	slot_t             mem [DEPTH];
	rel_t              rel_buf [RELEASE_LIMIT];
	logic [REL_CNT_W-1:0] rel_cnt_q;
	logic [REL_IDX_W-1:0] emit_idx_q;
	logic [15:0]       cancel_ref_q;

	logic [CNT_W-1:0]  rd_cnt_q;
	logic              chk_s1;
	logic [IDX_W-1:0]  idx_s1;
	slot_t             rd_s1;

	logic              best_v_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [TIME_W-1:0] best_due_q;
	logic [15:0]       best_age_q;
	rel_t              best_rel_q;
	logic              found_q;

	logic              ready_q;
	logic [31:0]       ttn_q;

	logic              out_v_q;
	status_t           out_status_q;
	rel_t              out_rel_q;
	logic              out_last_q;
	logic              out_ready_q;
	logic [31:0]       out_ttn_q;

	// free slot search, lowest index wins
	logic              free_found;
	logic [IDX_W-1:0]  free_idx;
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	logic [TIME_W:0]   due_sum;
	logic [TIME_W-1:0] due_sat;
	assign due_sum = {1'b0, now_q} + {{(TIME_W - 31){1'b0}}, head.delay_ms};
	assign due_sat = due_sum[TIME_W] ? {TIME_W{1'b1}} : due_sum[TIME_W-1:0];

	assign pop = (state_q == S_IDLE) && head_valid;
	logic sched_wr;
	assign sched_wr = pop && (head.kind == CMD_SCHED) && free_found;

	logic scan_issue;
	assign scan_issue = (state_q == S_SCAN) && (rd_cnt_q < CNT_W'(DEPTH));

	always_ff @(posedge clk) begin
		if (sched_wr) begin
			mem[free_idx] <= '{due: due_sat, event_handle: head.event_handle,
				target_ref: head.target_ref, send_ref: head.send_ref, order: ins_cnt_q};
		end
		if (scan_issue) begin
			rd_s1 <= mem[rd_cnt_q[IDX_W-1:0]];
		end
	end

	// candidate compare for the earliest-entry scan
	logic [15:0] cand_age;
	logic        cand_better;
	assign cand_age    = ins_cnt_q - rd_s1.order;
	assign cand_better = valid_q[idx_s1] && (!best_v_q || (rd_s1.due < best_due_q) ||
		((rd_s1.due == best_due_q) && (cand_age > best_age_q)));

	logic              best_due_now;
	logic [TIME_W-1:0] diff;
	assign best_due_now = best_v_q && (best_due_q <= now_q);
	assign diff         = best_due_q - now_q;

	logic emit_go, emit_last;
	assign emit_go   = (state_q == S_EMIT) && (!out_v_q || rsp.ready);
	assign emit_last = (rel_cnt_q == '0) ||
		({1'b0, emit_idx_q} == rel_cnt_q - REL_CNT_W'(1));

	always_ff @(posedge clk) begin
		if ((state_q == S_DECIDE) && (mode_q == MODE_REL) && best_due_now &&
			(rel_cnt_q < REL_CNT_W'(RELEASE_LIMIT))) begin
			rel_buf[rel_cnt_q[REL_IDX_W-1:0]] <= best_rel_q;
		end
		if (emit_go) begin
			if (rel_cnt_q != '0) begin
				out_status_q <= STAT_RELEASED;
				out_rel_q    <= rel_buf[emit_idx_q];
			end else begin
				out_status_q <= status_q;
				out_rel_q    <= '0;
			end
			out_last_q  <= emit_last;
			out_ready_q <= ready_q;
			out_ttn_q   <= ttn_q;
		end
		if (chk_s1 && cand_better && (mode_q != MODE_CANCEL)) begin
			best_idx_q <= idx_s1;
			best_due_q <= rd_s1.due;
			best_age_q <= cand_age;
			best_rel_q <= '{event_handle: rd_s1.event_handle, target_ref: rd_s1.target_ref,
				send_ref: rd_s1.send_ref};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			mode_q       <= MODE_FINAL;
			status_q     <= STAT_NONE_READY;
			now_q        <= '0;
			ins_cnt_q    <= '0;
			valid_q      <= '0;
			rel_cnt_q    <= '0;
			emit_idx_q   <= '0;
			cancel_ref_q <= '0;
			rd_cnt_q     <= '0;
			chk_s1       <= 1'b0;
			idx_s1       <= '0;
			best_v_q     <= 1'b0;
			found_q      <= 1'b0;
			ready_q      <= 1'b0;
			ttn_q        <= '1;
			out_v_q      <= 1'b0;
		end else begin
			chk_s1 <= scan_issue;
			idx_s1 <= rd_cnt_q[IDX_W-1:0];
			if (emit_go) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (head_valid) begin
						rel_cnt_q    <= '0;
						rd_cnt_q     <= '0;
						best_v_q     <= 1'b0;
						found_q      <= 1'b0;
						cancel_ref_q <= head.send_ref;
						mode_q       <= MODE_FINAL;
						state_q      <= S_SCAN;
						unique case (head.kind)
							CMD_SCHED: begin
								if (free_found) begin
									valid_q[free_idx] <= 1'b1;
									ins_cnt_q <= ins_cnt_q + 16'd1;
									status_q  <= STAT_SCHEDULED;
								end else begin
									status_q <= STAT_FULL;
								end
							end
							CMD_NULL:        status_q <= STAT_NULL;
							CMD_TICK: begin
								if (now_q != {TIME_W{1'b1}}) begin
									now_q <= now_q + TIME_W'(1);
								end
								mode_q <= MODE_REL;
							end
							CMD_CANCEL:      mode_q <= MODE_CANCEL;
							CMD_CANCEL_NONE: status_q <= STAT_NOT_FOUND;
							default:         status_q <= STAT_NONE_READY;
						endcase
					end
				end
				S_SCAN: begin
					if (scan_issue) begin
						rd_cnt_q <= rd_cnt_q + CNT_W'(1);
					end
					if (chk_s1) begin
						if (mode_q == MODE_CANCEL) begin
							if (valid_q[idx_s1] && (rd_s1.send_ref == cancel_ref_q)) begin
								valid_q[idx_s1] <= 1'b0;
								found_q <= 1'b1;
							end
						end else if (cand_better) begin
							best_v_q <= 1'b1;
						end
						if (idx_s1 == IDX_W'(DEPTH - 1)) begin
							state_q <= S_DECIDE;
						end
					end
				end
				S_DECIDE: begin
					rd_cnt_q <= '0;
					best_v_q <= 1'b0;
					priority if (mode_q == MODE_CANCEL) begin
						status_q <= found_q ? STAT_CANCELLED : STAT_NOT_FOUND;
						mode_q   <= MODE_FINAL;
						state_q  <= S_SCAN;
					end else if ((mode_q == MODE_REL) && best_due_now &&
						(rel_cnt_q < REL_CNT_W'(RELEASE_LIMIT))) begin
						valid_q[best_idx_q] <= 1'b0;
						rel_cnt_q <= rel_cnt_q + REL_CNT_W'(1);
						state_q   <= S_SCAN;
					end else begin
						if ((mode_q == MODE_REL) && (rel_cnt_q == '0)) begin
							status_q <= STAT_NONE_READY;
						end
						ready_q <= best_due_now;
						if (!best_v_q) begin
							ttn_q <= '1;
						end else if (best_due_now) begin
							ttn_q <= '0;
						end else begin
							ttn_q <= (diff[TIME_W-1:32] != '0) ? 32'hFFFF_FFFF : diff[31:0];
						end
						emit_idx_q <= '0;
						state_q    <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						emit_idx_q <= emit_idx_q + REL_IDX_W'(1);
						if (emit_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid            = out_v_q;
	assign rsp.status           = out_status_q;
	assign rsp.out_event_handle = out_rel_q.event_handle;
	assign rsp.out_target_ref   = out_rel_q.target_ref;
	assign rsp.out_send_ref     = out_rel_q.send_ref;
	assign rsp.ready_pending    = out_ready_q;
	assign rsp.time_to_next     = out_ttn_q;
	assign rsp.last             = out_last_q;

	`DETQ_ASSERT_SAME(a_rel_handle, out_v_q && (out_status_q == STAT_RELEASED), out_rel_q.event_handle != 16'd0, "released beat carries null handle")
	`DETQ_ASSERT_NEXT(a_sched_fill, sched_wr, $countones(valid_q) == $countones($past(valid_q)) + 1, "schedule did not fill one slot")
	`DETQ_ASSERT_NEXT(a_rel_limit, (state_q == S_DECIDE) && (mode_q == MODE_REL) && (rel_cnt_q == REL_CNT_W'(RELEASE_LIMIT)), state_q == S_EMIT, "release run passed its limit")

endmodule

`default_nettype wire

// File: src/delayed_event_timer_queue.sv
// Top level of the delayed event timer queue: front classifier plus back engine.
// Depends on detq_pkg, detq_ifs, detq_front and detq_back.
//
// Usage:
//   cmd : valid/ready command beats (opcode, delay_ms, event_handle, target_ref,
//         send_ref). Schedule, tick or cancel.
//   rsp : valid/ready response beats. Schedule, cancel and an idle tick give one
//         beat; a tick that releases gives one beat per released entry, earliest
//         due first, ties oldest first, at most 16, last set on the final beat.
// Timing: every command runs one or more scans over the QUEUE_DEPTH slots, one
//   slot per cycle through the registered slot memory read. Schedule, no-op and
//   cancel of id 0 take one scan, other cancels two, a tick one scan per released
//   entry plus one. Beats then leave at one per cycle while rsp is ready, and the
//   next command starts once the last beat is in the output register.
// A two-entry command queue takes new beats while the engine works; a stalled
//   rsp holds the engine in its emit step, and the command queue then fills and
//   drops cmd.ready.
// Reset (arst_n low): time to zero, all slots empty, queues and output emptied.
`default_nettype none

module delayed_event_timer_queue #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	detq_cmd_if.sink    cmd,
	detq_rsp_if.source  rsp
);
	import detq_pkg::*;

	logic head_valid;
	cmd_t head;
	logic pop;

	detq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	detq_back #(
		.DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.rsp        (rsp)
	);

endmodule

`default_nettype wire

// File: tb/sv/detq_timer_checker.sv
// Scoreboard for the delayed event timer queue: watches cmd and rsp beats,
// predicts the response beats of each command and compares them. Needs detq_pkg and detq_ifs.
module detq_timer_checker (
	input  wire        clk,
	input  wire        arst_n,
	detq_cmd_if        cmd,
	detq_rsp_if        rsp,
	output int         fail_count,
	output int         outstanding
);
	import detq_pkg::*;

	localparam int DEPTH = 16;
	localparam logic [47:0] CLOCK_MAX = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		status_t     status;
		logic [15:0] ev;
		logic [7:0]  tg;
		logic [15:0] sd;
		logic        rdy;
		logic [31:0] ttn;
		logic        last;
	} rsp_beat_t;

	rsp_beat_t   expected_beats[$];
	logic [47:0] now_ms;
	logic        used[DEPTH];
	logic [47:0] due_at[DEPTH];
	logic [15:0] ev_of[DEPTH];
	logic [7:0]  tg_of[DEPTH];
	logic [15:0] sd_of[DEPTH];
	logic [15:0] seq_of[DEPTH];
	logic [15:0] seq_next;

	// Earliest due slot, ties go to the larger wrapped age.
	function automatic int earliest_slot();
		int best;
		logic [15:0] age_i, age_b;
		best = -1;
		for (int i = 0; i < DEPTH; i++) begin
			if (used[i]) begin
				age_i = seq_next - seq_of[i];
				if (best >= 0)
					age_b = seq_next - seq_of[best];
				if (best < 0 || due_at[i] < due_at[best] ||
						(due_at[i] == due_at[best] && age_i > age_b))
					best = i;
			end
		end
		return best;
	endfunction

	task automatic predict_beats(input logic [1:0] op, input logic [31:0] dly,
			input logic [15:0] h, input logic [7:0] t, input logic [15:0] s);
		rsp_beat_t   beats[$];
		rsp_beat_t   b;
		int          slot;
		int          e;
		logic        found;
		logic [48:0] sum;
		logic [47:0] diff;
		logic        rdy;
		logic [31:0] ttn;
		b = '0;
		case (opcode_t'(op))
			OP_SCHEDULE: begin
				if (h == 0) begin
					b.status = STAT_NULL;
				end else begin
					slot = -1;
					for (int i = DEPTH - 1; i >= 0; i--)
						if (!used[i]) slot = i;
					if (slot < 0) begin
						b.status = STAT_FULL;
					end else begin
						sum = {1'b0, now_ms} + {17'd0, dly};
						due_at[slot] = sum[48] ? CLOCK_MAX : sum[47:0];
						used[slot]   = 1'b1;
						ev_of[slot]  = h;
						tg_of[slot]  = t;
						sd_of[slot]  = s;
						seq_of[slot] = seq_next;
						seq_next     = seq_next + 16'd1;
						b.status     = STAT_SCHEDULED;
					end
				end
				beats = {beats, b};
			end
			OP_TICK: begin
				if (now_ms != CLOCK_MAX) now_ms = now_ms + 48'd1;
				while (beats.size() < RELEASE_LIMIT) begin
					e = earliest_slot();
					if (e < 0 || due_at[e] > now_ms) break;
					b.status = STAT_RELEASED;
					b.ev = ev_of[e];
					b.tg = tg_of[e];
					b.sd = sd_of[e];
					used[e] = 1'b0;
					beats = {beats, b};
				end
				if (beats.size() == 0) begin
					b.status = STAT_NONE_READY;
					beats = {beats, b};
				end
			end
			OP_CANCEL: begin
				found = 1'b0;
				if (s != 0)
					for (int i = 0; i < DEPTH; i++)
						if (used[i] && sd_of[i] == s) begin
							used[i] = 1'b0;
							found = 1'b1;
						end
				b.status = found ? STAT_CANCELLED : STAT_NOT_FOUND;
				beats = {beats, b};
			end
			default: begin
				b.status = STAT_NONE_READY;
				beats = {beats, b};
			end
		endcase
		// Summary fields are common to every beat of the command.
		rdy = 1'b0;
		ttn = 32'hFFFF_FFFF;
		e = earliest_slot();
		if (e >= 0) begin
			if (due_at[e] <= now_ms) begin
				rdy = 1'b1;
				ttn = 32'd0;
			end else begin
				diff = due_at[e] - now_ms;
				ttn = (diff > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : diff[31:0];
			end
		end
		foreach (beats[k]) begin
			beats[k].rdy  = rdy;
			beats[k].ttn  = ttn;
			beats[k].last = (k == beats.size() - 1);
			expected_beats = {expected_beats, beats[k]};
		end
	endtask

	assign outstanding = expected_beats.size();

	always @(posedge clk or negedge arst_n) begin
		rsp_beat_t got;
		rsp_beat_t want;
		if (!arst_n) begin
			expected_beats.delete();
			now_ms   = '0;
			seq_next = '0;
			for (int i = 0; i < DEPTH; i++) used[i] = 1'b0;
			fail_count = 0;
		end else begin
			if (cmd.valid && cmd.ready)
				predict_beats(cmd.opcode, cmd.delay_ms, cmd.event_handle,
					cmd.target_ref, cmd.send_ref);
			if (rsp.valid && rsp.ready) begin
				got.status = status_t'(rsp.status);
				got.ev     = rsp.out_event_handle;
				got.tg     = rsp.out_target_ref;
				got.sd     = rsp.out_send_ref;
				got.rdy    = rsp.ready_pending;
				got.ttn    = rsp.time_to_next;
				got.last   = rsp.last;
				if (expected_beats.size() == 0) begin
					$display("%0t: unexpected rsp beat %p", $time, got);
					fail_count++;
				end else begin
					want = expected_beats.pop_front();
					if (got !== want) begin
						$display("%0t: rsp mismatch expected %p actual %p", $time,
							want, got);
						fail_count++;
					end
				end
			end
		end
	end
endmodule

// File: tb/sv/tb.sv
// Top of the timer queue testbench: clock, reset, command stimulus, rsp stalls, verdict.
// Needs detq_pkg, detq_ifs, delayed_event_timer_queue and detq_timer_checker.
module tb;
	import detq_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int RANDOM_ITEMS = 220;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   outstanding;
	int   cycles = 0;
	int   ready_mode = 0;

	detq_cmd_if cmd ();
	detq_rsp_if rsp ();

	delayed_event_timer_queue #(.QUEUE_DEPTH(16)) u_dut (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .rsp(rsp)
	);

	detq_timer_checker u_chk (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .rsp(rsp),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	always #5 clk = ~clk;

	// Cycle watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// rsp stall pattern: ready follows a randomly picked mode; mode 0 never stalls.
	always @(posedge clk) begin
		if (cycles % 64 == 0) ready_mode <= $urandom_range(0, 3);
		case (ready_mode)
			0: rsp.ready <= 1'b1;
			1: rsp.ready <= ($urandom_range(0, 3) != 0);
			2: rsp.ready <= ($urandom_range(0, 3) == 0);
			default: rsp.ready <= (cycles % 5 < 2);
		endcase
	end

	int burst_left = 0;

	// Drive one command beat and hold it until accepted. valid stays up
	// inside a burst; a gap lowers it afterwards.
	task automatic send_cmd(input opcode_t op, input logic [31:0] dly,
			input logic [15:0] h, input logic [7:0] t, input logic [15:0] s);
		int gap;
		cmd.valid        <= 1'b1;
		cmd.opcode       <= op;
		cmd.delay_ms     <= dly;
		cmd.event_handle <= h;
		cmd.target_ref   <= t;
		cmd.send_ref     <= s;
		do @(posedge clk); while (!cmd.ready);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
			if (gap > 0) begin
				cmd.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic tick_n(input int n);
		for (int i = 0; i < n; i++)
			send_cmd(OP_TICK, $urandom, 16'($urandom), 8'($urandom), 16'($urandom));
	endtask

	initial begin
		int pick;
		logic [31:0] dly;
		cmd.valid        = 1'b0;
		cmd.opcode       = OP_TICK;
		cmd.delay_ms     = '0;
		cmd.event_handle = '0;
		cmd.target_ref   = '0;
		cmd.send_ref     = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty tick, null handle, zero delay released only on tick.
		send_cmd(OP_TICK, 32'd0, 16'd0, 8'd0, 16'd0);
		send_cmd(OP_SCHEDULE, 32'd5, 16'd0, 8'hFF, 16'hFFFF);
		send_cmd(OP_SCHEDULE, 32'd0, 16'hFFFF, 8'hFF, 16'hFFFF);
		send_cmd(OP_SCHEDULE, 32'hFFFF_FFFF, 16'h0001, 8'h00, 16'h0000);
		tick_n(1);
		// Cancel: id 0 and an unknown id; unused opcode.
		send_cmd(OP_CANCEL, 32'd0, 16'd0, 8'd0, 16'd0);
		send_cmd(OP_CANCEL, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 16'h1234);
		send_cmd(OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
		// Fill the queue with ties at one due time, then overflow it.
		for (int i = 0; i < 15; i++)
			send_cmd(OP_SCHEDULE, 32'd2, 16'(i + 100), 8'(i), 16'(i % 3 + 1));
		send_cmd(OP_SCHEDULE, 32'd2, 16'hAAAA, 8'h55, 16'h7);
		send_cmd(OP_CANCEL, 32'd0, 16'd0, 8'd0, 16'd2);
		send_cmd(OP_CANCEL, 32'd0, 16'd0, 8'd0, 16'hFFFF);
		tick_n(2);

		// Random: mostly short delays and small id pools so entries collide.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				dly = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6);
				send_cmd(OP_SCHEDULE, dly,
					($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom),
					8'($urandom), ($urandom_range(0, 7) == 0) ? 16'($urandom) :
					16'($urandom_range(0, 5)));
			end else if (pick < 85) begin
				tick_n(1);
			end else if (pick < 97) begin
				send_cmd(OP_CANCEL, $urandom, 16'($urandom), 8'($urandom),
					($urandom_range(0, 7) == 0) ? 16'($urandom) :
					16'($urandom_range(0, 5)));
			end else begin
				send_cmd(OP_UNUSED, $urandom, 16'($urandom), 8'($urandom),
					16'($urandom));
			end
		end

		cmd.valid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
